// ----- hw/rtl/ilt_pkg.sv -----
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types and constants for the layout tokenizer: token codes, field
// widths and the per-word decision passed from the decide logic to the top.
// ----------------------------------------------------------------------------
package ilt_pkg;

  localparam int COL_W    = 16;
  localparam int IN_BYTES = 3;
  localparam int OUT_W    = 8;

  typedef enum logic [1:0] {
    TOK_NONE    = 2'd0,
    TOK_NEWLINE = 2'd1,
    TOK_INDENT  = 2'd2,
    TOK_DEDENT  = 2'd3
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic        push;
    logic        pop;
  } ilt_op_t;

endpackage

// ----- hw/rtl/ilt_ram.sv -----
// ----------------------------------------------------------------------------
// ilt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ilt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ilt_decide.sv -----
// ----------------------------------------------------------------------------
// ilt_decide
// Picks the layout token for one request from the request fields and the
// current top of the indent stack, and says whether the stack pushes or pops.
// ----------------------------------------------------------------------------
module ilt_decide
  import ilt_pkg::*;
(
  input  logic             accept_newline,
  input  logic             accept_indent,
  input  logic             accept_dedent,
  input  logic             error_recovery,
  input  logic             run_had_newline,
  input  logic             at_end_of_file,
  input  logic [COL_W-1:0] next_column,
  input  logic             next_closes_bracket,
  input  logic             stack_empty,
  input  logic             stack_full,
  input  logic [COL_W-1:0] stack_top,
  output ilt_op_t          op
);

  always_comb begin
    op.kind = TOK_NONE;
    op.push = 1'b0;
    op.pop  = 1'b0;
    if (error_recovery) begin
      op.kind = TOK_NONE;
    end else if (at_end_of_file) begin
      if (accept_dedent && !stack_empty) begin
        op.kind = TOK_DEDENT;
        op.pop  = 1'b1;
      end else if (run_had_newline && accept_newline) begin
        op.kind = TOK_NEWLINE;
      end
    end else if (!run_had_newline) begin
      // closing bracket on the same line shuts one level
      if (accept_dedent && !stack_empty && next_closes_bracket) begin
        op.kind = TOK_DEDENT;
        op.pop  = 1'b1;
      end
    end else if (next_column > stack_top && next_column != '0) begin
      if (accept_indent) begin
        op.kind = TOK_INDENT;
        // full stack: emit the token, drop the push
        op.push = !stack_full;
      end
    end else if (stack_top > next_column) begin
      if (accept_dedent) begin
        op.kind = TOK_DEDENT;
        op.pop  = 1'b1;
      end
    end else if (accept_newline) begin
      op.kind = TOK_NEWLINE;
    end
  end

endmodule

// ----- hw/rtl/indent_layout_tokenizer.sv -----
// ----------------------------------------------------------------------------
// indent_layout_tokenizer
// Offside-rule layout tokenizer: one token request in, one token kind out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel, one word per request, and each yields
//   exactly one result word on the m_ channel (token kind NONE, NEWLINE,
//   INDENT or DEDENT). The result is registered and stands on m_tvalid in the
//   cycle after the request is accepted. Throughput is one request per cycle
//   while the receiver takes each result. The top of the indent stack lives in
//   a register; the RAM read port always prefetches the entry below it, at
//   the address given by the next stack count, so a pop in one cycle and any
//   request in the next see the correct top without a bubble.
//   The stack RAM has STACK_DEPTH entries; a push at a full stack still emits
//   INDENT but leaves the stack as it is.
//   Reset empties the stack (count and top cleared, RAM contents untouched)
//   and clears m_tvalid (m_tdata is not reset); no clearing pass is needed.
//   When the receiver stalls, the result word holds in the output register
//   and s_tready drops until it is taken; a new request is taken in the same
//   cycle that the waiting result leaves.
// ----------------------------------------------------------------------------
module indent_layout_tokenizer
  import ilt_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [0] accept_newline, [1] accept_indent, [2] accept_dedent,
  // [3] error_recovery, [4] run_had_newline, [5] at_end_of_file,
  // [21:6] next_column, [22] next_closes_bracket, [23] zero
  input  logic [IN_BYTES*8-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [1:0] token_kind, [7:2] zero
  output logic [OUT_W-1:0]     m_tdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic             accept;
  ilt_op_t          op;
  logic [CW-1:0]    count, count_next;
  logic [COL_W-1:0] top, top_next;
  logic [COL_W-1:0] second;
  logic [CW-1:0]    raddr_full;
  logic             stack_empty, stack_full;

  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign stack_empty = (count == '0);
  assign stack_full  = (count == CW'(STACK_DEPTH));

  ilt_decide u_decide (
    .accept_newline      (s_tdata[0]),
    .accept_indent       (s_tdata[1]),
    .accept_dedent       (s_tdata[2]),
    .error_recovery      (s_tdata[3]),
    .run_had_newline     (s_tdata[4]),
    .at_end_of_file      (s_tdata[5]),
    .next_column         (s_tdata[21:6]),
    .next_closes_bracket (s_tdata[22]),
    .stack_empty         (stack_empty),
    .stack_full          (stack_full),
    .stack_top           (top),
    .op                  (op)
  );

  always_comb begin
    count_next = count;
    top_next   = top;
    if (accept && op.push) begin
      count_next = count + CW'(1);
      top_next   = s_tdata[21:6];
    end else if (accept && op.pop) begin
      count_next = count - CW'(1);
      // last level gone: empty stack reads as column 0
      top_next   = (count == CW'(1)) ? '0 : second;
    end
  end

  // prefetch the entry below the next top; never the entry being written
  assign raddr_full = count_next - CW'(2);

  ilt_ram #(
    .WIDTH (COL_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (accept && op.push),
    .waddr (count[AW-1:0]),
    .wdata (s_tdata[21:6]),
    .raddr (raddr_full[AW-1:0]),
    .rdata (second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      top      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      top   <= top_next;
      if (s_tready) begin
        m_tvalid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(OUT_W-2){1'b0}}, op.kind};
    end
  end

endmodule

// ----- hw/rtl/ilt_checker.sv -----
// ----------------------------------------------------------------------------
// ilt_checker
// Port-level checks for the layout tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ilt_checker
  import ilt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_BYTES*8-1:0] s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_W-1:0]      m_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // every accepted request yields a result word in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request produced no result");

  // error recovery never produces a token
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[3] |=> m_tdata[1:0] == TOK_NONE)
    else $error("token emitted during error recovery");

  // a run without a line break never opens a line or a level
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tdata[3] && !s_tdata[4] && !s_tdata[5]
    |=> m_tdata[1:0] == TOK_NONE || m_tdata[1:0] == TOK_DEDENT)
    else $error("newline or indent without a line break");

endmodule

bind indent_layout_tokenizer ilt_checker u_ilt_checker (.*);
